// ----- hdl/tths_pkg.sv -----
// Package for the two-way hash table: request, response, slot and state types,
// command codes and default constants.
// No dependencies.
`timescale 1ns / 1ps

package tths_pkg;

    localparam int DEF_BUCKET_COUNT = 4096;
    localparam int DEF_MATE_VALUE   = 32000;
    localparam int TAG_SHIFT        = 41;
    localparam int MATE_WINDOW      = 100;

    localparam logic [13:0] FILL_MAX  = 14'h3FFF;
    localparam logic [7:0]  GEN_START = 8'd1;
    localparam logic [7:0]  GEN_LAST  = 8'd255;

    typedef enum logic [1:0] {
        CMD_STORE    = 2'd0,
        CMD_PROBE    = 2'd1,
        CMD_NEXT_GEN = 2'd2,
        CMD_CLEAR    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_WIPE,
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        t_cmd               cmd;
        logic [63:0]        hash;
        logic [15:0]        best_move;
        logic signed [15:0] score;
        logic [7:0]         depth;
        logic [7:0]         bound_flag;
    } t_req;

    typedef struct packed {
        logic               hit;
        logic [15:0]        out_move;
        logic signed [15:0] out_score;
        logic [7:0]         out_depth;
        logic [7:0]         out_flag;
        logic [7:0]         out_generation;
        logic [7:0]         out_mate_distance;
        logic [13:0]        filled_count;
    } t_rsp;

    typedef struct packed {
        logic [31:0] tag;
        logic [15:0] move;
        logic [15:0] score;
        logic [7:0]  gen;
        logic [7:0]  depth;
        logic [7:0]  flag;
        logic [7:0]  mate;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

endpackage

// ----- hdl/two_way_hash_table_store_probe.sv -----
// Top level of the two-way hash table: bucket memory, command sequencer
// and response register.
// Depends on tths_pkg and tths_ram.
`timescale 1ns / 1ps

// The block takes requests on the i_req channel and returns exactly one
// response per request on the o_rsp channel, both with valid and ready.
// A store writes a search result into the two-slot bucket picked by hash
// bits 41 and up; a probe returns the best matching slot; the other
// commands advance the generation stamp or clear the whole table.
// Every response carries the count of filled slots after its request.
// A request is taken only while the sequencer is idle. The bucket is read
// at the edge of acceptance; in the execute state that follows, the bucket
// is decided on and written back as the response register is loaded, and
// that state waits while the register still holds a stalled response. The
// block takes no new request until the last one has left the sequencer,
// which does the single read and write of the bucket memory. A clear request
// answers like the others and then walks the memory, one bucket a cycle,
// during which no request is accepted. After reset the same walk empties
// the memory before the first request is taken. A stalled response is held
// in the output register; the next request is still accepted, and its
// result waits in the sequencer until the register is free.
module two_way_hash_table_store_probe
    import tths_pkg::*;
#(
    parameter int BUCKET_COUNT = DEF_BUCKET_COUNT,
    parameter int MATE_VALUE   = DEF_MATE_VALUE
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    localparam int AW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam logic [AW-1:0] IDX_TOP = AW'(BUCKET_COUNT - 1);
    localparam int BW = 2 * SLOT_W;

    localparam logic signed [17:0] MATE_HI = 18'(MATE_VALUE - MATE_WINDOW);
    localparam logic signed [17:0] MATE_LO = 18'(MATE_WINDOW - MATE_VALUE);
    localparam logic [15:0] MATE_POS = 16'(MATE_VALUE);
    localparam logic [15:0] MATE_NEG = 16'(-MATE_VALUE);
    localparam logic [7:0]  MATE_LSB = MATE_POS[7:0];

    t_state        r_state, n_state;
    t_req          r_req;
    logic [7:0]    r_gen, n_gen;
    logic [13:0]   r_fill, n_fill;
    logic [AW-1:0] r_wipe_addr, n_wipe_addr;
    logic          r_rsp_valid, n_rsp_valid;
    t_rsp          r_rsp, n_rsp;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [BW-1:0] w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic [BW-1:0] w_rdata;

    t_slot              w_slot_a;
    t_slot              w_slot_b;
    t_slot              w_new;
    t_slot              w_sel;
    logic signed [17:0] w_score_ext;
    logic [31:0]        w_tag;
    logic [AW-1:0]      w_idx;
    logic               w_a_empty;
    logic               w_b_empty;
    logic               w_to_b;
    logic               w_fills;
    logic [13:0]        w_fill_inc;
    logic [13:0]        w_fill_store;
    logic               w_ma;
    logic               w_mb;
    logic               w_take_a;
    logic               w_rsp_free;
    t_rsp               w_probe_rsp;
    t_rsp               w_empty_rsp;
    logic [BW-1:0]      w_store_data;

    tths_ram #(
        .WIDTH(BW),
        .DEPTH(BUCKET_COUNT)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_raddr  = i_req.hash[TAG_SHIFT +: AW] & IDX_TOP;
    assign w_idx    = r_req.hash[TAG_SHIFT +: AW] & IDX_TOP;
    assign w_tag    = r_req.hash[31:0];
    assign w_slot_a = w_rdata[SLOT_W-1:0];
    assign w_slot_b = w_rdata[BW-1:SLOT_W];

    always_comb begin
        w_score_ext = {{2{r_req.score[15]}}, r_req.score};
        w_new.tag   = w_tag;
        w_new.move  = r_req.best_move;
        w_new.gen   = r_gen;
        w_new.depth = r_req.depth;
        w_new.flag  = r_req.bound_flag;
        w_new.score = r_req.score;
        w_new.mate  = 8'd0;
        priority if (w_score_ext > MATE_HI) begin
            w_new.score = MATE_POS;
            w_new.mate  = MATE_LSB - r_req.score[7:0];
        end else if (w_score_ext < MATE_LO) begin
            w_new.score = MATE_NEG;
            w_new.mate  = MATE_LSB + r_req.score[7:0];
        end else begin
            w_new.mate = 8'd0;
        end
    end

    always_comb begin
        w_a_empty = (w_slot_a.gen == 8'd0);
        w_b_empty = (w_slot_b.gen == 8'd0);
        priority if (w_slot_a.tag == w_tag) begin
            w_to_b  = 1'b0;
            w_fills = w_a_empty;
        end else if (w_slot_b.tag == w_tag) begin
            w_to_b  = 1'b1;
            w_fills = w_b_empty;
        end else if (w_a_empty) begin
            w_to_b  = 1'b0;
            w_fills = 1'b1;
        end else if (w_b_empty) begin
            w_to_b  = 1'b1;
            w_fills = 1'b1;
        end else if (w_slot_a.depth < w_slot_b.depth ||
                     (w_slot_a.depth == w_slot_b.depth && w_slot_a.gen < w_slot_b.gen)) begin
            w_to_b  = 1'b0;
            w_fills = 1'b0;
        end else begin
            w_to_b  = 1'b1;
            w_fills = 1'b0;
        end
        w_store_data = w_to_b ? {w_new, w_slot_a} : {w_slot_b, w_new};
        w_fill_inc   = (r_fill != FILL_MAX) ? r_fill + 14'd1 : r_fill;
        w_fill_store = w_fills ? w_fill_inc : r_fill;
    end

    always_comb begin
        w_ma     = (w_slot_a.tag == w_tag) && !w_a_empty;
        w_mb     = (w_slot_b.tag == w_tag) && !w_b_empty;
        w_take_a = w_ma && (!w_mb || w_slot_a.depth > w_slot_b.depth ||
                   (w_slot_a.depth == w_slot_b.depth && w_slot_a.gen >= w_slot_b.gen));
        w_sel    = w_take_a ? w_slot_a : w_slot_b;

        w_empty_rsp              = '0;
        w_empty_rsp.filled_count = r_fill;

        w_probe_rsp = w_empty_rsp;
        if (w_ma || w_mb) begin
            w_probe_rsp.hit               = 1'b1;
            w_probe_rsp.out_move          = w_sel.move;
            w_probe_rsp.out_score         = $signed(w_sel.score);
            w_probe_rsp.out_depth         = w_sel.depth;
            w_probe_rsp.out_flag          = w_sel.flag;
            w_probe_rsp.out_generation    = w_sel.gen;
            w_probe_rsp.out_mate_distance = w_sel.mate;
        end
    end

    assign w_rsp_free = !r_rsp_valid || i_rsp_ready;

    always_comb begin
        n_state     = r_state;
        n_gen       = r_gen;
        n_fill      = r_fill;
        n_wipe_addr = r_wipe_addr;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        o_req_ready = 1'b0;
        w_re        = 1'b0;
        w_we        = 1'b0;
        w_waddr     = w_idx;
        w_wdata     = w_store_data;
        unique case (r_state)
            ST_WIPE: begin
                w_we    = 1'b1;
                w_waddr = r_wipe_addr;
                w_wdata = '0;
                if (r_wipe_addr == IDX_TOP) begin
                    n_state = ST_IDLE;
                end else begin
                    n_wipe_addr = r_wipe_addr + AW'(1);
                end
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
                w_re        = i_req_valid;
                if (i_req_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_rsp_free) begin
                    n_state     = ST_IDLE;
                    n_rsp_valid = 1'b1;
                    n_rsp       = w_empty_rsp;
                    unique case (r_req.cmd)
                        CMD_STORE: begin
                            w_we               = 1'b1;
                            n_fill             = w_fill_store;
                            n_rsp.filled_count = w_fill_store;
                        end
                        CMD_PROBE: begin
                            n_rsp = w_probe_rsp;
                        end
                        CMD_NEXT_GEN: begin
                            n_gen = (r_gen == GEN_LAST) ? GEN_START : r_gen + 8'd1;
                        end
                        CMD_CLEAR: begin
                            n_gen              = GEN_START;
                            n_fill             = '0;
                            n_rsp.filled_count = '0;
                            n_wipe_addr        = '0;
                            n_state            = ST_WIPE;
                        end
                        default: begin
                            n_rsp = w_empty_rsp;
                        end
                    endcase
                end
            end
            default: begin
                n_state     = ST_WIPE;
                n_wipe_addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_WIPE;
            r_gen       <= GEN_START;
            r_fill      <= '0;
            r_wipe_addr <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gen       <= n_gen;
            r_fill      <= n_fill;
            r_wipe_addr <= n_wipe_addr;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (o_req_ready && i_req_valid) begin
            r_req <= i_req;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

// ----- hdl/tths_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module tths_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/tths_checker.sv -----
// Port-level checks for the two-way hash table, and the bind that attaches
// them to the top level. Depends on tths_pkg and two_way_hash_table_store_probe.
`timescale 1ns / 1ps

module tths_checker
    import tths_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic o_req_ready,
    input logic o_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp o_rsp
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("response changed or dropped while stalled");

    a_req_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request accepted in two consecutive cycles");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid && !o_req_ready)
        else $error("activity directly after reset");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp.hit |-> o_rsp.out_move == 16'd0 &&
        o_rsp.out_score == 16'sd0 && o_rsp.out_depth == 8'd0 &&
        o_rsp.out_flag == 8'd0 && o_rsp.out_generation == 8'd0 &&
        o_rsp.out_mate_distance == 8'd0)
        else $error("entry fields set on a response without a hit");

    a_hit_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.hit |-> o_rsp.out_generation != 8'd0)
        else $error("hit returned an empty slot");

endmodule

bind two_way_hash_table_store_probe tths_checker u_tths_checker (.*);

// ----- sim/two_way_hash_table_store_probe_tb.sv -----
// Self-checking testbench for two_way_hash_table_store_probe: a table of directed
// requests, then random store, probe, generation and clear traffic against a predictor.
// Depends on tths_pkg and the two_way_hash_table_store_probe RTL.
`timescale 1ns / 1ps

module two_way_hash_table_store_probe_tb;
    import tths_pkg::*;

    localparam int BUCKETS   = DEF_BUCKET_COUNT;
    localparam int MATE      = DEF_MATE_VALUE;
    localparam int BIDX_W    = $clog2(BUCKETS);
    localparam int LIMIT     = 1_000_000;
    localparam int HOLD_LEN  = 300;
    localparam int RAND_REQS = 1250;

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_stim_row;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    logic i_rsp_ready = 1'b0;
    t_req i_req       = '0;
    logic o_req_ready;
    logic o_rsp_valid;
    t_rsp o_rsp;

    // Predicted contents of the table.
    t_slot       tt_mem [0:2*BUCKETS-1];
    logic [7:0]  tt_gen;
    logic [13:0] tt_fill;

    t_rsp        awaited_rsp_q [$];
    t_stim_row   dir_rows [$];
    logic [BIDX_W-1:0] bucket_pool [0:7];
    logic [31:0] tag_pool [0:5];

    int mismatches = 0;
    int cycles     = 0;
    int burst_left = 0;
    int n_store = 0, n_probe = 0, n_hit = 0, n_next = 0, n_clear = 0;
    int n_wrap = 0, n_mate = 0;

    int hold_left = 0, holds_asked = 0, holds_done = 0;
    int rx_mode = 0, rx_mode_left = 0;

    two_way_hash_table_store_probe u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [63:0] mk_hash(input int unsigned bucket, input logic [31:0] tag);
        return (64'(bucket) << TAG_SHIFT) | 64'(tag);
    endfunction

    function automatic t_req mk_req(input t_cmd c, input logic [63:0] h, input int mv,
                                    input int sc, input int dp, input int fl);
        t_req r;
        r.cmd        = c;
        r.hash       = h;
        r.best_move  = 16'(mv);
        r.score      = 16'(sc);
        r.depth      = 8'(dp);
        r.bound_flag = 8'(fl);
        return r;
    endfunction

    function automatic t_rsp mk_rsp(input bit hit, input int mv, input int sc, input int dp,
                                    input int fl, input int gen, input int mate, input int fill);
        t_rsp r;
        r.hit               = hit;
        r.out_move          = 16'(mv);
        r.out_score         = 16'(sc);
        r.out_depth         = 8'(dp);
        r.out_flag          = 8'(fl);
        r.out_generation    = 8'(gen);
        r.out_mate_distance = 8'(mate);
        r.filled_count      = 14'(fill);
        return r;
    endfunction

    function automatic void table_wipe();
        foreach (tt_mem[k]) tt_mem[k] = '0;
        tt_gen  = GEN_START;
        tt_fill = '0;
    endfunction

    function automatic t_rsp table_apply(input t_req r);
        t_rsp        res;
        t_slot       ne, sa, sb, found;
        int          s;
        int unsigned base;
        logic [31:0] tag;
        bit          ma, mb, a_empty, b_empty, pick_a, fill_new;
        res  = '0;
        base = 2 * int'((r.hash >> TAG_SHIFT) & 64'(BUCKETS - 1));
        tag  = r.hash[31:0];
        sa   = tt_mem[base];
        sb   = tt_mem[base+1];
        case (r.cmd)
            CMD_STORE: begin
                n_store++;
                s        = $signed(r.score);
                ne.tag   = tag;
                ne.move  = r.best_move;
                ne.gen   = tt_gen;
                ne.depth = r.depth;
                ne.flag  = r.bound_flag;
                ne.mate  = 8'd0;
                ne.score = 16'(s);
                if (s > MATE - MATE_WINDOW) begin
                    ne.mate  = 8'(MATE - s);
                    ne.score = 16'(MATE);
                    n_mate++;
                end else if (s < MATE_WINDOW - MATE) begin
                    ne.mate  = 8'(MATE + s);
                    ne.score = 16'(-MATE);
                    n_mate++;
                end
                a_empty = (sa.gen == 8'd0);
                b_empty = (sb.gen == 8'd0);
                if (sa.tag == tag) begin
                    pick_a   = 1'b1;
                    fill_new = a_empty;
                end else if (sb.tag == tag) begin
                    pick_a   = 1'b0;
                    fill_new = b_empty;
                end else if (a_empty || b_empty) begin
                    pick_a   = a_empty;
                    fill_new = 1'b1;
                end else begin
                    pick_a   = (sa.depth < sb.depth) ||
                               (sa.depth == sb.depth && sa.gen < sb.gen);
                    fill_new = 1'b0;
                end
                if (fill_new && tt_fill != FILL_MAX) tt_fill = tt_fill + 14'd1;
                if (pick_a) tt_mem[base] = ne;
                else tt_mem[base+1] = ne;
            end
            CMD_PROBE: begin
                n_probe++;
                ma = (sa.tag == tag) && (sa.gen != 8'd0);
                mb = (sb.tag == tag) && (sb.gen != 8'd0);
                if (ma || mb) begin
                    if (ma && mb)
                        found = (sa.depth > sb.depth ||
                                 (sa.depth == sb.depth && sa.gen >= sb.gen)) ? sa : sb;
                    else
                        found = ma ? sa : sb;
                    n_hit++;
                    res.hit               = 1'b1;
                    res.out_move          = found.move;
                    res.out_score         = found.score;
                    res.out_depth         = found.depth;
                    res.out_flag          = found.flag;
                    res.out_generation    = found.gen;
                    res.out_mate_distance = found.mate;
                end
            end
            CMD_NEXT_GEN: begin
                n_next++;
                if (tt_gen == GEN_LAST) n_wrap++;
                tt_gen = (tt_gen == GEN_LAST) ? GEN_START : tt_gen + 8'd1;
            end
            default: begin
                n_clear++;
                table_wipe();
            end
        endcase
        res.filled_count = tt_fill;
        return res;
    endfunction

    function automatic logic [63:0] rand_hash();
        logic [63:0] h;
        h = {$urandom, $urandom};
        if ($urandom_range(0, 19) != 0)
            h[TAG_SHIFT +: BIDX_W] = bucket_pool[$urandom_range(0, 7)];
        if ($urandom_range(0, 9) != 0) h[31:0] = tag_pool[$urandom_range(0, 5)];
        return h;
    endfunction

    task automatic offer(input t_req r, input bit typed, input t_rsp typed_rsp);
        t_rsp pred;
        i_req       <= r;
        i_req_valid <= 1'b1;
        do @(posedge i_clk); while (o_req_ready !== 1'b1);
        pred = table_apply(r);
        awaited_rsp_q.push_back(typed ? typed_rsp : pred);
    endtask

    task automatic sender_pace();
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 40 : 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end
    endtask

    task automatic wait_all_answered();
        do @(posedge i_clk); while (awaited_rsp_q.size() != 0);
    endtask

    // Receiver: changing stall patterns, plus long hold-offs on demand.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_rsp_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (holds_done != holds_asked) begin
            i_rsp_ready <= 1'b0;
            hold_left   <= HOLD_LEN;
            holds_done  <= holds_done + 1;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= $urandom_range(0, 2);
                rx_mode_left <= $urandom_range(10, 200);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0:       i_rsp_ready <= 1'b1;
                1:       i_rsp_ready <= ($urandom_range(0, 3) != 0);
                default: i_rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (o_rsp_valid === 1'b1 && i_rsp_ready === 1'b1) begin
            if (awaited_rsp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("t=%0t response with none awaited: %p", $realtime, o_rsp);
            end else begin
                want = awaited_rsp_q.pop_front();
                if (o_rsp.hit !== want.hit || o_rsp.out_move !== want.out_move ||
                    o_rsp.out_score !== want.out_score || o_rsp.out_depth !== want.out_depth ||
                    o_rsp.out_flag !== want.out_flag ||
                    o_rsp.out_generation !== want.out_generation ||
                    o_rsp.out_mate_distance !== want.out_mate_distance ||
                    o_rsp.filled_count !== want.filled_count) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"t=%0t mismatch, expected hit %0b move %h score %0d",
                                  " depth %0d flag %0d gen %0d mate %0d fill %0d"},
                                 $realtime, want.hit, want.out_move, want.out_score,
                                 want.out_depth, want.out_flag, want.out_generation,
                                 want.out_mate_distance, want.filled_count);
                        $display({"    actual hit %0b move %h score %0d depth %0d flag %0d",
                                  " gen %0d mate %0d fill %0d"},
                                 o_rsp.hit, o_rsp.out_move, o_rsp.out_score, o_rsp.out_depth,
                                 o_rsp.out_flag, o_rsp.out_generation, o_rsp.out_mate_distance,
                                 o_rsp.filled_count);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("two_way_hash_table_store_probe_tb: done, errors");
            $finish;
        end
    end

    initial begin
        t_req r;
        int   pick;
        int   clears_left;
        bit   wrap_phase;

        table_wipe();
        clears_left = 16;

        // Directed requests; typed results only where they are obvious.
        dir_rows.push_back('{mk_req(CMD_PROBE, 64'h0, 0, 0, 0, 0), 1'b1,
                             mk_rsp(0, 0, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_req(CMD_STORE, 64'h0, 16'hFFFF, 32767, 255, 255), 1'b1,
                             mk_rsp(0, 0, 0, 0, 0, 0, 0, 1)});
        dir_rows.push_back('{mk_req(CMD_PROBE, 64'h0, 0, 0, 0, 0), 1'b1,
                             mk_rsp(1, 16'hFFFF, 32000, 255, 255, 1, 1, 1)});
        dir_rows.push_back('{mk_req(CMD_STORE, '1, 0, -32768, 0, 0), 1'b1,
                             mk_rsp(0, 0, 0, 0, 0, 0, 0, 2)});
        dir_rows.push_back('{mk_req(CMD_PROBE, '1, 0, 0, 0, 0), 1'b1,
                             mk_rsp(1, 0, -32000, 0, 0, 1, 0, 2)});
        dir_rows.push_back('{mk_req(CMD_STORE, mk_hash(0, 1), 16'h1234, 31900, 5, 1), 1'b0, '0});
        dir_rows.push_back('{mk_req(CMD_PROBE, mk_hash(0, 1), 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_req(CMD_NEXT_GEN, 64'h0, 0, 0, 0, 0), 1'b1,
                             mk_rsp(0, 0, 0, 0, 0, 0, 0, 3)});
        dir_rows.push_back('{mk_req(CMD_STORE, mk_hash(0, 2), 16'h4321, 31901, 5, 2), 1'b0, '0});
        dir_rows.push_back('{mk_req(CMD_PROBE, mk_hash(0, 2), 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_req(CMD_STORE, mk_hash(1, 10), 1, -31900, 3, 3), 1'b0, '0});
        dir_rows.push_back('{mk_req(CMD_NEXT_GEN, 64'h0, 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_req(CMD_STORE, mk_hash(1, 11), 2, -31901, 3, 1), 1'b0, '0});
        dir_rows.push_back('{mk_req(CMD_STORE, mk_hash(1, 12), 3, 100, 3, 2), 1'b0, '0});
        dir_rows.push_back('{mk_req(CMD_PROBE, mk_hash(1, 10), 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_req(CMD_PROBE, mk_hash(1, 12), 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_req(CMD_PROBE, mk_hash(1, 11), 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_req(CMD_PROBE, mk_hash(2, 1), 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_req(CMD_STORE, mk_hash(1, 11), 7, 0, 200, 0), 1'b0, '0});
        dir_rows.push_back('{mk_req(CMD_PROBE, mk_hash(1, 11), 0, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_req(CMD_CLEAR, 64'h0, 0, 0, 0, 0), 1'b1,
                             mk_rsp(0, 0, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_req(CMD_PROBE, 64'h0, 0, 0, 0, 0), 1'b1,
                             mk_rsp(0, 0, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_req(CMD_STORE, 64'h0, 5, -1, 1, 0), 1'b1,
                             mk_rsp(0, 0, 0, 0, 0, 0, 0, 1)});
        dir_rows.push_back('{mk_req(CMD_PROBE, 64'h0, 0, 0, 0, 0), 1'b1,
                             mk_rsp(1, 5, -1, 1, 0, 1, 0, 1)});

        bucket_pool[0] = '0;
        bucket_pool[1] = '1;
        for (int k = 2; k < 8; k++) bucket_pool[k] = BIDX_W'($urandom);
        tag_pool[0] = 32'h0;
        tag_pool[1] = 32'hFFFF_FFFF;
        for (int k = 2; k < 6; k++) tag_pool[k] = $urandom;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            offer(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].rsp);
            sender_pace();
        end
        i_req_valid <= 1'b0;
        wait_all_answered();

        // The middle stretch is mostly generation steps so that the stamp wraps.
        for (int i = 0; i < RAND_REQS; i++) begin
            wrap_phase = (i >= 300 && i < 750);
            pick = $urandom_range(0, 99);
            r.hash       = rand_hash();
            r.best_move  = 16'($urandom);
            r.bound_flag = 8'($urandom);
            r.depth      = ($urandom_range(0, 4) < 3) ? 8'($urandom_range(0, 3)) : 8'($urandom);
            case ($urandom_range(0, 3))
                0:       r.score = 16'($urandom_range(31850, 32767));
                1:       r.score = 16'(-$urandom_range(31850, 32768));
                2:       r.score = 16'($urandom);
                default: r.score = 16'($urandom_range(0, 400) - 200);
            endcase
            if (wrap_phase)
                r.cmd = (pick < 65) ? CMD_NEXT_GEN : (pick < 88) ? CMD_STORE : CMD_PROBE;
            else if (pick < 45)
                r.cmd = CMD_STORE;
            else if (pick < 88)
                r.cmd = CMD_PROBE;
            else if (pick < 98 || clears_left == 0)
                r.cmd = CMD_NEXT_GEN;
            else begin
                r.cmd = CMD_CLEAR;
                clears_left--;
            end
            offer(r, 1'b0, '0);
            if (i == 150) holds_asked <= holds_asked + 1;
            if (i == 900) begin
                i_req_valid <= 1'b0;
                wait_all_answered();
            end else begin
                sender_pace();
            end
        end

        i_req_valid <= 1'b0;
        wait_all_answered();
        repeat (20) @(posedge i_clk);
        mismatches += awaited_rsp_q.size();

        $display({"two_way_hash_table_store_probe_tb: %0d stores, %0d probes with %0d hits,",
                  " %0d generation steps, %0d clears"},
                 n_store, n_probe, n_hit, n_next, n_clear);
        $display({"two_way_hash_table_store_probe_tb: %0d mate scores packed,",
                  " %0d generation wraps, %0d mismatches"},
                 n_mate, n_wrap, mismatches);
        if (mismatches == 0) begin
            $display("two_way_hash_table_store_probe_tb: done, clean");
        end else begin
            $display("two_way_hash_table_store_probe_tb: done, errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/tths_pkg.sv
hdl/tths_ram.sv
hdl/two_way_hash_table_store_probe.sv
hdl/tths_checker.sv
sim/two_way_hash_table_store_probe_tb.sv
